/* rtl/sled_pkg.sv */
// Shared types, character codes and helper functions for the string literal decoder.
`default_nettype none

package sled_pkg;

	localparam int unsigned FifoDepth = 4;
	localparam int unsigned PtrW      = $clog2(FifoDepth);
	localparam int unsigned CntW      = $clog2(FifoDepth + 1);

	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChBslash = 8'h5c;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChSeven  = 8'h37;
	localparam logic [7:0] ChNine   = 8'h39;
	localparam logic [7:0] ChLowA   = 8'h61;
	localparam logic [7:0] ChLowF   = 8'h66;
	localparam logic [7:0] ChUpA    = 8'h41;
	localparam logic [7:0] ChUpF    = 8'h46;
	localparam logic [7:0] ChLowX   = 8'h78;
	localparam logic [7:0] HexTen   = 8'd10;

	typedef enum logic [2:0] {
		MODE_OPEN,
		MODE_TEXT,
		MODE_BETWEEN,
		MODE_ESC,
		MODE_HEX,
		MODE_OCT
	} sled_mode_t;

	typedef struct packed {
		sled_mode_t  mode;
		logic [7:0]  esc_val;
		logic [1:0]  oct_cnt;
	} sled_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       done;
	} sled_res_t;

	// up to two result words per input word
	typedef struct packed {
		logic [1:0] cnt;
		sled_res_t  r1;
		sled_res_t  r0;
	} sled_out_t;

	function automatic sled_out_t push_byte(sled_out_t o, logic [7:0] b);
		sled_out_t t;
		t = o;
		if (o.cnt == 2'd0) begin
			t.r0 = '{data: b, has_byte: 1'b1, done: 1'b0};
		end else begin
			t.r1 = '{data: b, has_byte: 1'b1, done: 1'b0};
		end
		t.cnt = o.cnt + 2'd1;
		return t;
	endfunction

	// simple escape letters; valid bit in [8]
	function automatic logic [8:0] simple_escape(logic [7:0] c);
		logic [8:0] r;
		r = 9'd0;
		unique case (c)
			8'h6e:   r = {1'b1, 8'd10};   // n
			8'h74:   r = {1'b1, 8'd9};    // t
			8'h76:   r = {1'b1, 8'd11};   // v
			8'h62:   r = {1'b1, 8'd8};    // b
			8'h72:   r = {1'b1, 8'd13};   // r
			8'h66:   r = {1'b1, 8'd12};   // f
			8'h61:   r = {1'b1, 8'd7};    // a
			8'h5c:   r = {1'b1, 8'd92};
			8'h3f:   r = {1'b1, 8'd63};
			8'h27:   r = {1'b1, 8'd39};
			8'h22:   r = {1'b1, 8'd34};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// hex digit value; valid bit in [4]
	function automatic logic [4:0] hex_digit(logic [7:0] c);
		logic [7:0] v;
		logic [4:0] r;
		v = 8'd0;
		r = 5'd0;
		if (c >= ChZero && c <= ChNine) begin
			v = c - ChZero;
			r = {1'b1, v[3:0]};
		end else if (c >= ChLowA && c <= ChLowF) begin
			v = c - ChLowA + HexTen;
			r = {1'b1, v[3:0]};
		end else if (c >= ChUpA && c <= ChUpF) begin
			v = c - ChUpA + HexTen;
			r = {1'b1, v[3:0]};
		end
		return r;
	endfunction

	function automatic logic is_oct(logic [7:0] c);
		return (c >= ChZero) && (c <= ChSeven);
	endfunction

endpackage

`default_nettype wire

/* rtl/sled_decode.sv */
// Combinational decode of one raw byte against the current decoder state.
`default_nettype none

module sled_decode (
	input  wire logic [7:0]           char_s1,
	input  wire logic                 last_s1,
	input  wire sled_pkg::sled_state_t cur,
	output sled_pkg::sled_state_t     nxt,
	output sled_pkg::sled_out_t       res
);

	logic [8:0]  esc;
	logic [4:0]  hd;
	logic [7:0]  oct_d;
	logic        as_text;
	logic [1:0]  oct_inc;

	always_comb begin
		esc     = sled_pkg::simple_escape(char_s1);
		hd      = sled_pkg::hex_digit(char_s1);
		oct_d   = char_s1 - sled_pkg::ChZero;
		oct_inc = cur.oct_cnt + 2'd1;
		nxt     = cur;
		res     = '0;
		as_text = 1'b0;

		unique case (cur.mode)
			sled_pkg::MODE_OPEN: begin
				nxt.mode = sled_pkg::MODE_TEXT;
			end
			sled_pkg::MODE_TEXT: begin
				as_text = 1'b1;
			end
			sled_pkg::MODE_BETWEEN: begin
				if (char_s1 == sled_pkg::ChQuote) nxt.mode = sled_pkg::MODE_TEXT;
			end
			sled_pkg::MODE_ESC: begin
				if (esc[8]) begin
					res      = sled_pkg::push_byte(res, esc[7:0]);
					nxt.mode = sled_pkg::MODE_TEXT;
				end else if (char_s1 == sled_pkg::ChLowX) begin
					nxt.esc_val = 8'd0;
					nxt.mode    = sled_pkg::MODE_HEX;
				end else if (sled_pkg::is_oct(char_s1)) begin
					nxt.esc_val = oct_d;
					nxt.oct_cnt = 2'd1;
					nxt.mode    = sled_pkg::MODE_OCT;
				end else begin
					// unknown escape gives a zero, then the byte is plain text
					res     = sled_pkg::push_byte(res, 8'd0);
					as_text = 1'b1;
				end
			end
			sled_pkg::MODE_HEX: begin
				if (hd[4]) begin
					nxt.esc_val = {cur.esc_val[3:0], hd[3:0]};
				end else begin
					res         = sled_pkg::push_byte(res, cur.esc_val);
					nxt.esc_val = 8'd0;
					as_text     = 1'b1;
				end
			end
			sled_pkg::MODE_OCT: begin
				if (sled_pkg::is_oct(char_s1)) begin
					nxt.esc_val = {cur.esc_val[4:0], oct_d[2:0]};
					nxt.oct_cnt = oct_inc;
					if (oct_inc == 2'd3) begin
						res         = sled_pkg::push_byte(res, {cur.esc_val[4:0], oct_d[2:0]});
						nxt.esc_val = 8'd0;
						nxt.oct_cnt = 2'd0;
						nxt.mode    = sled_pkg::MODE_TEXT;
					end
				end else begin
					res         = sled_pkg::push_byte(res, cur.esc_val);
					nxt.esc_val = 8'd0;
					nxt.oct_cnt = 2'd0;
					as_text     = 1'b1;
				end
			end
			default: begin
				nxt.mode = sled_pkg::MODE_TEXT;
			end
		endcase

		if (as_text) begin
			priority if (char_s1 == sled_pkg::ChQuote) begin
				nxt.mode = sled_pkg::MODE_BETWEEN;
			end else if (char_s1 == sled_pkg::ChBslash) begin
				nxt.mode = sled_pkg::MODE_ESC;
			end else begin
				res      = sled_pkg::push_byte(res, char_s1);
				nxt.mode = sled_pkg::MODE_TEXT;
			end
		end

		if (last_s1) begin
			// flush an open numeric escape
			if ((nxt.mode == sled_pkg::MODE_HEX || nxt.mode == sled_pkg::MODE_OCT)
			    && res.cnt != 2'd2) begin
				res = sled_pkg::push_byte(res, nxt.esc_val);
			end
			if (res.cnt == 2'd0) begin
				res.cnt = 2'd1;
				res.r0  = '0;
			end
			if (res.cnt == 2'd1) res.r0.done = 1'b1;
			else res.r1.done = 1'b1;
			nxt.mode    = sled_pkg::MODE_OPEN;
			nxt.esc_val = 8'd0;
			nxt.oct_cnt = 2'd0;
		end
	end

endmodule

`default_nettype wire

/* rtl/string_literal_escape_decoder_top.sv */
// Top level: input register, decode, and a four-entry result queue.
// The first result word of an input word passes through the input register, then the result queue.
// Throughput: with out_ready held high, one input word per cycle while each yields at most one
// result word; words that yield two results drain at one result word per cycle through the queue.
// Reset: arst_n clears the decoder state to awaiting the opening quote and empties the queue.
`default_nettype none

module string_literal_escape_decoder_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_in,
	input  wire logic       last_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      byte_out,
	output logic            has_byte,
	output logic            done_out
);

	logic [7:0]            char_s1;
	logic                  last_s1;
	logic                  valid_s1;
	sled_pkg::sled_state_t state_q;
	sled_pkg::sled_state_t state_nxt;
	sled_pkg::sled_out_t   dec;

	sled_pkg::sled_res_t             fifo_q [sled_pkg::FifoDepth];
	logic [sled_pkg::PtrW-1:0]       wr_ptr_q;
	logic [sled_pkg::PtrW-1:0]       rd_ptr_q;
	logic [sled_pkg::CntW-1:0]       count_q;
	logic [sled_pkg::CntW-1:0]       dec_cnt;
	logic [sled_pkg::PtrW-1:0]       wr_ptr_p1;
	logic                            commit;
	logic                            in_acc;
	logic                            pop;

	sled_decode u_decode (
		.char_s1 (char_s1),
		.last_s1 (last_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (dec)
	);

	assign dec_cnt   = sled_pkg::CntW'(dec.cnt);
	assign wr_ptr_p1 = wr_ptr_q + sled_pkg::PtrW'(1);
	assign commit    = valid_s1 && (count_q <= sled_pkg::CntW'(sled_pkg::FifoDepth) - dec_cnt);
	assign in_ready  = !valid_s1 || commit;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;

	assign byte_out = fifo_q[rd_ptr_q].data;
	assign has_byte = fifo_q[rd_ptr_q].has_byte;
	assign done_out = fifo_q[rd_ptr_q].done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '{mode: sled_pkg::MODE_OPEN, esc_val: 8'd0, oct_cnt: 2'd0};
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_acc) valid_s1 <= 1'b1;
			else if (commit) valid_s1 <= 1'b0;
			if (commit) begin
				state_q  <= state_nxt;
				wr_ptr_q <= wr_ptr_q + sled_pkg::PtrW'(dec.cnt);
			end
			if (pop) rd_ptr_q <= rd_ptr_q + sled_pkg::PtrW'(1);
			count_q <= count_q + (commit ? dec_cnt : '0) - sled_pkg::CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1 <= char_in;
			last_s1 <= last_in;
		end
		if (commit) begin
			if (dec.cnt != 2'd0) fifo_q[wr_ptr_q] <= dec.r0;
			if (dec.cnt == 2'd2) fifo_q[wr_ptr_p1] <= dec.r1;
		end
	end

endmodule

`default_nettype wire
